/* hw/rtl/rbst_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbst_pkg
// Types shared by the slab units and the pipelined divider of the
// ray versus box slab test.
// ----------------------------------------------------------------------------
package rbst_pkg;

   typedef struct packed {
      logic neg_a;
      logic neg_b;
      logic dir_zero;
      logic in_slab;
   } rbst_flags_type;

endpackage
`default_nettype wire

/* hw/rtl/rbst_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbst_div
// Pipelined restoring divider, one quotient bit per register stage.
// Computes floor((num << FRAC_BITS) / den) on unsigned magnitudes and
// carries a set of flags alongside the data.
// ----------------------------------------------------------------------------
module rbst_div #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  wire                            clock,
   input  wire [COORD_WIDTH:0]            num,
   input  wire [COORD_WIDTH-1:0]          den,
   input  rbst_pkg::rbst_flags_type       flags_in,
   output logic [COORD_WIDTH+FRAC_BITS:0] quo,
   output rbst_pkg::rbst_flags_type       flags_out
);
   import rbst_pkg::*;

   localparam int QW = COORD_WIDTH + FRAC_BITS + 1;
   localparam int DW = COORD_WIDTH;

   logic [QW-1:0]  n_ff   [QW];
   logic [QW-1:0]  q_ff   [QW];
   logic [DW-1:0]  r_ff   [QW];
   logic [DW-1:0]  d_ff   [QW];
   rbst_flags_type f_ff   [QW];

   for (genvar i = 0; i < QW; i++) begin : g_stage
      logic [QW-1:0]  n_src;
      logic [QW-1:0]  q_src;
      logic [DW-1:0]  r_src;
      logic [DW-1:0]  d_src;
      rbst_flags_type f_src;
      logic [DW:0]    trial;
      logic           ge;

      if (i == 0) begin : g_first
         assign n_src = {num, {FRAC_BITS{1'b0}}};
         assign q_src = '0;
         assign r_src = '0;
         assign d_src = den;
         assign f_src = flags_in;
      end else begin : g_next
         assign n_src = n_ff[i-1];
         assign q_src = q_ff[i-1];
         assign r_src = r_ff[i-1];
         assign d_src = d_ff[i-1];
         assign f_src = f_ff[i-1];
      end

      assign trial = {r_src, n_src[QW-1]};
      assign ge    = trial >= {1'b0, d_src};

      always_ff @(posedge clock) begin
         n_ff[i] <= {n_src[QW-2:0], 1'b0};
         q_ff[i] <= {q_src[QW-2:0], ge};
         r_ff[i] <= ge ? DW'(trial - {1'b0, d_src}) : DW'(trial);
         d_ff[i] <= d_src;
         f_ff[i] <= f_src;
      end
   end

   assign quo       = q_ff[QW-1];
   assign flags_out = f_ff[QW-1];

endmodule
`default_nettype wire

/* hw/rtl/rbst_slab.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbst_slab
// One axis of the slab test: forms both distances, divides them by the
// direction, saturates, applies the sign and orders entry and exit.
// ----------------------------------------------------------------------------
module rbst_slab #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  wire                                   clock,
   input  wire signed [COORD_WIDTH-1:0]          lo,
   input  wire signed [COORD_WIDTH-1:0]          hi,
   input  wire signed [COORD_WIDTH-1:0]          org,
   input  wire signed [COORD_WIDTH-1:0]          dir,
   output logic signed [COORD_WIDTH+FRAC_BITS:0] t_entry,
   output logic signed [COORD_WIDTH+FRAC_BITS:0] t_exit,
   output logic                                  ok
);
   import rbst_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int TW = COORD_WIDTH + FRAC_BITS + 1;
   localparam logic [TW-1:0] LIM     = {2'b00, {(TW-2){1'b1}}};
   localparam logic [TW-1:0] NEG_INF = {1'b1, {(TW-1){1'b0}}};
   localparam logic [TW-1:0] POS_INF = {1'b0, {(TW-1){1'b1}}};

   logic signed [CW:0] da;
   logic signed [CW:0] db;
   logic [CW:0]        na_in;
   logic [CW:0]        nb_in;
   logic [CW-1:0]      dm_in;
   rbst_flags_type     fl_in;

   logic [CW:0]        na_ff;
   logic [CW:0]        nb_ff;
   logic [CW-1:0]      dm_ff;
   rbst_flags_type     fl_ff;

   logic [TW-1:0]      qa;
   logic [TW-1:0]      qb;
   rbst_flags_type     fl_div;
   logic [TW-1:0]      sa;
   logic [TW-1:0]      sb;

   logic signed [TW-1:0] ta_ff;
   logic signed [TW-1:0] tb_ff;
   logic                 dz_ff;
   logic                 ins_ff;

   logic signed [TW-1:0] te_ff;
   logic signed [TW-1:0] tx_ff;
   logic                 ok_ff;

   always_comb begin
      da           = $signed({lo[CW-1], lo}) - $signed({org[CW-1], org});
      db           = $signed({hi[CW-1], hi}) - $signed({org[CW-1], org});
      na_in        = da[CW] ? (CW+1)'(-da) : da;
      nb_in        = db[CW] ? (CW+1)'(-db) : db;
      dm_in        = dir[CW-1] ? CW'(-dir) : dir;
      fl_in.neg_a    = da[CW] ^ dir[CW-1];
      fl_in.neg_b    = db[CW] ^ dir[CW-1];
      fl_in.dir_zero = dir == '0;
      fl_in.in_slab  = (lo <= org) && (org <= hi);
   end

   always_ff @(posedge clock) begin
      na_ff <= na_in;
      nb_ff <= nb_in;
      dm_ff <= dm_in;
      fl_ff <= fl_in;
   end

   rbst_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_a (
      .clock     (clock),
      .num       (na_ff),
      .den       (dm_ff),
      .flags_in  (fl_ff),
      .quo       (qa),
      .flags_out (fl_div)
   );

   rbst_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_b (
      .clock     (clock),
      .num       (nb_ff),
      .den       (dm_ff),
      .flags_in  (fl_ff),
      .quo       (qb),
      .flags_out ()
   );

   assign sa = (qa > LIM) ? LIM : qa;
   assign sb = (qb > LIM) ? LIM : qb;

   always_ff @(posedge clock) begin
      ta_ff  <= fl_div.neg_a ? TW'(-sa) : sa;
      tb_ff  <= fl_div.neg_b ? TW'(-sb) : sb;
      dz_ff  <= fl_div.dir_zero;
      ins_ff <= fl_div.in_slab;
   end

   always_ff @(posedge clock) begin
      if (dz_ff) begin
         te_ff <= NEG_INF;
         tx_ff <= POS_INF;
         ok_ff <= ins_ff;
      end else begin
         te_ff <= (ta_ff > tb_ff) ? tb_ff : ta_ff;
         tx_ff <= (ta_ff > tb_ff) ? ta_ff : tb_ff;
         ok_ff <= 1'b1;
      end
   end

   assign t_entry = te_ff;
   assign t_exit  = tx_ff;
   assign ok      = ok_ff;

endmodule
`default_nettype wire

/* hw/rtl/ray_box_slab_test.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ray_box_slab_test
// Ray versus axis-aligned box hit test by the slab method, fully pipelined.
//
//   channel   ports                    direction
//   request   start, busy, req_*       in, one beat per cycle
//   response  rsp_strobe, rsp_hit      out, one beat per request
//
// A new beat is taken in every cycle; busy is always low.
// Each beat passes the input register, the one-bit-per-stage dividers and
// the sign and order registers of three slab units, then the combining registers.
// Reset clears only the valid bits; beats in flight are dropped.
// The response side cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module ray_box_slab_test #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire signed [COORD_WIDTH-1:0] req_box_min_x,
   input  wire signed [COORD_WIDTH-1:0] req_box_min_y,
   input  wire signed [COORD_WIDTH-1:0] req_box_min_z,
   input  wire signed [COORD_WIDTH-1:0] req_box_max_x,
   input  wire signed [COORD_WIDTH-1:0] req_box_max_y,
   input  wire signed [COORD_WIDTH-1:0] req_box_max_z,
   input  wire signed [COORD_WIDTH-1:0] req_origin_x,
   input  wire signed [COORD_WIDTH-1:0] req_origin_y,
   input  wire signed [COORD_WIDTH-1:0] req_origin_z,
   input  wire signed [COORD_WIDTH-1:0] req_dir_x,
   input  wire signed [COORD_WIDTH-1:0] req_dir_y,
   input  wire signed [COORD_WIDTH-1:0] req_dir_z,
   output logic                         rsp_strobe,
   output logic                         rsp_hit
);
   import rbst_pkg::*;

   localparam int TW  = COORD_WIDTH + FRAC_BITS + 1;
   localparam int LAT = TW + 5;

   logic signed [TW-1:0] xe, xx, ye, yx, ze, zx;
   logic                 xok, yok, zok;

   logic [LAT-1:0]       valid_ff;

   logic                 xy_ok_ff;
   logic signed [TW-1:0] tmin_ff, tmax_ff, ze_ff, zx_ff;
   logic                 zok_ff;
   logic                 hit_ff;

   rbst_slab #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_slab_x (
      .clock (clock), .lo (req_box_min_x), .hi (req_box_max_x),
      .org (req_origin_x), .dir (req_dir_x),
      .t_entry (xe), .t_exit (xx), .ok (xok)
   );

   rbst_slab #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_slab_y (
      .clock (clock), .lo (req_box_min_y), .hi (req_box_max_y),
      .org (req_origin_y), .dir (req_dir_y),
      .t_entry (ye), .t_exit (yx), .ok (yok)
   );

   rbst_slab #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_slab_z (
      .clock (clock), .lo (req_box_min_z), .hi (req_box_max_z),
      .org (req_origin_z), .dir (req_dir_z),
      .t_entry (ze), .t_exit (zx), .ok (zok)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[LAT-2:0], start};
      end
   end

   always_ff @(posedge clock) begin
      xy_ok_ff <= xok && yok && !(xe > yx) && !(ye > xx);
      tmin_ff  <= (ye > xe) ? ye : xe;
      tmax_ff  <= (yx < xx) ? yx : xx;
      ze_ff    <= ze;
      zx_ff    <= zx;
      zok_ff   <= zok;
   end

   always_ff @(posedge clock) begin
      hit_ff <= xy_ok_ff && zok_ff && !(tmin_ff > zx_ff) && !(ze_ff > tmax_ff);
   end

   assign busy       = 1'b0;
   assign rsp_strobe = valid_ff[LAT-1];
   assign rsp_hit    = hit_ff;

endmodule
`default_nettype wire

/* hw/rtl/rbst_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbst_checker
// Port-level checks of the ray versus box slab test, bound to the top level.
// ----------------------------------------------------------------------------
module rbst_checker #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input wire clock,
   input wire reset,
   input wire start,
   input wire busy,
   input wire rsp_strobe
);
   localparam int LAT = COORD_WIDTH + FRAC_BITS + 6;

   a_never_busy : assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised on a pipeline that never holds");

   a_beat_returns : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_strobe)
      else $error("accepted beat produced no response");

   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, LAT))
      else $error("response without a matching request");

endmodule

bind ray_box_slab_test rbst_checker #(
   .COORD_WIDTH (COORD_WIDTH),
   .FRAC_BITS   (FRAC_BITS)
) u_rbst_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe)
);
`default_nettype wire
